[rtl/gwsc_pkg.sv]
`default_nettype none

package gwsc_pkg;

   // geometry
   localparam int MAX_WIDTH_DEF = 256;
   localparam int WORD_LEN      = 4;
   localparam int CH_W          = 8;
   localparam int HIST          = WORD_LEN - 1;   // cells ahead of the current one
   localparam int HIST_W        = HIST * CH_W;
   localparam int WORD_W        = WORD_LEN * CH_W;
   localparam int ROW_WIDTH_W   = 9;
   localparam int HITS_W        = 4;
   localparam int TOTAL_W       = 20;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
   localparam logic [1:0]         ROWS_FULL = 2'd3;

   // letters of the default word
   localparam logic [CH_W-1:0] LETTER_X = 8'h58;
   localparam logic [CH_W-1:0] LETTER_M = 8'h4D;
   localparam logic [CH_W-1:0] LETTER_A = 8'h41;
   localparam logic [CH_W-1:0] LETTER_S = 8'h53;

   localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST   = 9'd140;
   localparam logic [WORD_W-1:0]      SEARCH_WORD_RST = {LETTER_X, LETTER_M, LETTER_A, LETTER_S};

   // register indexes
   localparam int   CSR_INDEX_W     = 1;
   localparam logic CSR_ROW_WIDTH   = 1'b0;
   localparam logic CSR_SEARCH_WORD = 1'b1;

   // which windows ending on a cell lie fully inside the grid
   typedef struct packed {
      logic last;        // cell closes the grid
      logic row_ok;      // three cells to the left in this row
      logic col_ok;      // three full rows above
      logic diag_l_ok;   // three cells to the right in this row
   } cell_flags_type;

   // per column of the row above: the three cells that lead into it,
   // oldest in the high byte
   typedef struct packed {
      logic [HIST_W-1:0] vert;
      logic [HIST_W-1:0] diag_r;
      logic [HIST_W-1:0] diag_l;
   } line_word_type;

   // matches of a four-cell window, forward and reversed
   function automatic logic [1:0] score(input logic [WORD_W-1:0] win,
                                        input logic [WORD_W-1:0] word);
      logic [WORD_W-1:0] flip;
      logic              fwd;
      logic              rev;
      for (int i = 0; i < WORD_LEN; i++) begin
         flip[i*CH_W +: CH_W] = word[(WORD_LEN-1-i)*CH_W +: CH_W];
      end
      fwd = (win == word);
      rev = (win == flip);
      return {1'b0, fwd} + {1'b0, rev};
   endfunction

endpackage

`default_nettype wire

[rtl/grid_word_search_counter.sv]
// grid_word_search_counter: counts a four-letter word in a character grid,
// read in all eight directions, with the grid streamed in raster order.
//
// req channel: one character word per handshake (req_ch), req_last_of_grid
// on the final character. rsp channel: one result word per character, in
// order: hits ending on that cell, the saturating grid total and grid_done.
// csr port: csr_write_en with csr_index 0 sets the row width, index 1 the
// search word (first letter in the high byte); write only when idle.
//
// a character passes the queue, stage one and the result register in order.
// one character per cycle unless rsp_ready stalls; the line memory takes two
// reads and one write every cycle, a bypass covers back-to-back columns.
// a 4-entry queue separates classification from scoring, and the result
// register lets the next character be taken while a result waits.
//
// reset: queue and pipeline empty, position and total clear, row width 140,
// search word XMAS. the line memory needs no clearing pass.
// rsp_ready low holds the result; the queue fills, then req_ready drops.
`default_nettype none

module grid_word_search_counter #(
   parameter int MAX_WIDTH = gwsc_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input words
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [gwsc_pkg::CH_W-1:0]           req_ch,
   input  wire logic                                req_last_of_grid,
   // result words
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [gwsc_pkg::HITS_W-1:0]              rsp_hits_here,
   output logic [gwsc_pkg::TOTAL_W-1:0]             rsp_running_total,
   output logic                                     rsp_grid_done,
   // register writes
   input  wire logic                                csr_write_en,
   input  wire logic [gwsc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [gwsc_pkg::WORD_W-1:0]         csr_wdata
);
   import gwsc_pkg::*;

   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int ENTRY_W = CH_W + CW + $bits(cell_flags_type);

   // configuration registers
   logic [ROW_WIDTH_W-1:0] row_width_ff, row_width_in;
   logic [WORD_W-1:0]      search_word_ff, search_word_in;

   // front to queue
   logic                   push;
   logic [CH_W-1:0]        push_ch;
   logic [CW-1:0]          push_col;
   cell_flags_type         push_flags;
   logic                   queue_full;

   // queue to back
   logic                   pop;
   logic                   head_valid;
   logic [ENTRY_W-1:0]     head_data;
   logic [CH_W-1:0]        head_ch;
   logic [CW-1:0]          head_col;
   cell_flags_type         head_flags;

   always_comb begin
      row_width_in   = row_width_ff;
      search_word_in = search_word_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_ROW_WIDTH: begin
               row_width_in = csr_wdata[ROW_WIDTH_W-1:0];
            end
            CSR_SEARCH_WORD: begin
               search_word_in = csr_wdata;
            end
            default: begin
               row_width_in = row_width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff   <= ROW_WIDTH_RST;
         search_word_ff <= SEARCH_WORD_RST;
      end else begin
         row_width_ff   <= row_width_in;
         search_word_ff <= search_word_in;
      end
   end

   // front: tracks column and rows above, flags the windows that fit
   gwsc_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_ch           (req_ch),
      .req_last_of_grid (req_last_of_grid),
      .row_width        (row_width_ff),
      .queue_full       (queue_full),
      .push             (push),
      .push_ch          (push_ch),
      .push_col         (push_col),
      .push_flags       (push_flags)
   );

   gwsc_queue #(
      .DATA_W (ENTRY_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  ({push_ch, push_col, push_flags}),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   assign {head_ch, head_col, head_flags} = head_data;

   // back: line memory, window compare, total, result register
   gwsc_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (head_valid),
      .q_ch              (head_ch),
      .q_col             (head_col),
      .q_flags           (head_flags),
      .pop               (pop),
      .search_word       (search_word_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hits_here     (rsp_hits_here),
      .rsp_running_total (rsp_running_total),
      .rsp_grid_done     (rsp_grid_done)
   );

endmodule

`default_nettype wire

[rtl/gwsc_front.sv]
`default_nettype none

module gwsc_front #(
   parameter int MAX_WIDTH = gwsc_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [gwsc_pkg::CH_W-1:0]            req_ch,
   input  wire logic                                 req_last_of_grid,
   input  wire logic [gwsc_pkg::ROW_WIDTH_W-1:0]     row_width,
   input  wire logic                                 queue_full,
   output logic                                      push,
   output logic [gwsc_pkg::CH_W-1:0]                 push_ch,
   output logic [$clog2(MAX_WIDTH)-1:0]              push_col,
   output gwsc_pkg::cell_flags_type                  push_flags
);
   import gwsc_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = (CW > ROW_WIDTH_W) ? CW + 2 : ROW_WIDTH_W + 2;

   logic [CW-1:0] column_ff, column_in;
   logic [1:0]    rows_seen_ff, rows_seen_in;
   logic [WW-1:0] width_eff;
   logic [WW-1:0] col_ext;
   logic          row_end;

   // zero acts as one, too wide is clipped
   always_comb begin
      if (row_width == '0) begin
         width_eff = WW'(1);
      end else if (WW'(row_width) > WW'(MAX_WIDTH)) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = WW'(row_width);
      end
   end

   assign col_ext = WW'(column_ff);
   assign row_end = (col_ext + WW'(1)) >= width_eff;

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;
   assign push_ch   = req_ch;
   assign push_col  = column_ff;

   always_comb begin
      push_flags.last      = req_last_of_grid;
      push_flags.row_ok    = col_ext >= WW'(HIST);
      push_flags.col_ok    = rows_seen_ff == ROWS_FULL;
      push_flags.diag_l_ok = (col_ext + WW'(HIST)) < width_eff;
   end

   always_comb begin
      column_in    = column_ff;
      rows_seen_in = rows_seen_ff;
      if (push) begin
         if (req_last_of_grid) begin
            column_in    = '0;
            rows_seen_in = '0;
         end else if (row_end) begin
            column_in    = '0;
            rows_seen_in = (rows_seen_ff == ROWS_FULL) ? ROWS_FULL : rows_seen_ff + 2'd1;
         end else begin
            column_in = column_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         rows_seen_ff <= '0;
      end else begin
         column_ff    <= column_in;
         rows_seen_ff <= rows_seen_in;
      end
   end

endmodule

`default_nettype wire

[rtl/gwsc_queue.sv]
`default_nettype none

module gwsc_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = gwsc_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output logic [DATA_W-1:0]      head_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]     count_ff, count_in;

   assign full       = count_ff == NW'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/gwsc_back.sv]
`default_nettype none

module gwsc_back #(
   parameter int MAX_WIDTH = gwsc_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              q_valid,
   input  wire logic [gwsc_pkg::CH_W-1:0]         q_ch,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]      q_col,
   input  wire gwsc_pkg::cell_flags_type          q_flags,
   output logic                                   pop,
   input  wire logic [gwsc_pkg::WORD_W-1:0]       search_word,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [gwsc_pkg::HITS_W-1:0]            rsp_hits_here,
   output logic [gwsc_pkg::TOTAL_W-1:0]           rsp_running_total,
   output logic                                   rsp_grid_done
);
   import gwsc_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);

   // one word per column, built from the row above
   line_word_type line_mem [MAX_WIDTH];

   logic              s1_valid_ff, s1_valid_in;
   logic [CH_W-1:0]   s1_ch_ff;
   logic [CW-1:0]     s1_col_ff;
   cell_flags_type    s1_flags_ff;
   line_word_type     mid_rd_ff, hi_rd_ff;
   line_word_type     byp_word_ff;
   logic              byp_mid_ff, byp_hi_ff;
   line_word_type     left_word_ff;
   logic [HIST_W-1:0] recent_ff;
   logic [TOTAL_W-1:0] total_ff, total_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [HITS_W-1:0]  rsp_hits_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;
   logic               rsp_done_ff;

   logic [CW-1:0]      mid_addr, hi_addr;
   logic               s1_move;
   line_word_type      mid_word, hi_word, wr_word;
   logic [HITS_W-1:0]  hits;
   logic [TOTAL_W:0]   sum;
   logic [TOTAL_W-1:0] sum_sat;

   assign s1_move  = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign pop      = q_valid && (!s1_valid_ff || s1_move);
   assign mid_addr = q_col;
   assign hi_addr  = (q_col == CW'(MAX_WIDTH - 1)) ? q_col : q_col + CW'(1);

   // the word written by the cell leaving stage one is not yet in memory
   assign mid_word = byp_mid_ff ? byp_word_ff : mid_rd_ff;
   assign hi_word  = byp_hi_ff  ? byp_word_ff : hi_rd_ff;

   always_comb begin
      wr_word.vert   = {mid_word.vert[HIST_W-CH_W-1:0], s1_ch_ff};
      wr_word.diag_r = {left_word_ff.diag_r[HIST_W-CH_W-1:0], s1_ch_ff};
      wr_word.diag_l = {hi_word.diag_l[HIST_W-CH_W-1:0], s1_ch_ff};
   end

   always_comb begin
      hits = '0;
      if (s1_flags_ff.row_ok) begin
         hits = hits + HITS_W'(score({recent_ff, s1_ch_ff}, search_word));
      end
      if (s1_flags_ff.col_ok) begin
         hits = hits + HITS_W'(score({mid_word.vert, s1_ch_ff}, search_word));
      end
      if (s1_flags_ff.col_ok && s1_flags_ff.row_ok) begin
         hits = hits + HITS_W'(score({left_word_ff.diag_r, s1_ch_ff}, search_word));
      end
      if (s1_flags_ff.col_ok && s1_flags_ff.diag_l_ok) begin
         hits = hits + HITS_W'(score({hi_word.diag_l, s1_ch_ff}, search_word));
      end
   end

   assign sum     = {1'b0, total_ff} + (TOTAL_W + 1)'(hits);
   assign sum_sat = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (pop) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      total_in = total_ff;
      if (s1_move) begin
         total_in = s1_flags_ff.last ? '0 : sum_sat;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // line memory: one write, two reads
   always_ff @(posedge clock) begin
      if (s1_move) begin
         line_mem[s1_col_ff] <= wr_word;
      end
      if (pop) begin
         mid_rd_ff <= line_mem[mid_addr];
         hi_rd_ff  <= line_mem[hi_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_ch_ff    <= q_ch;
         s1_col_ff   <= q_col;
         s1_flags_ff <= q_flags;
         byp_word_ff <= wr_word;
         byp_mid_ff  <= s1_move && (s1_col_ff == mid_addr);
         byp_hi_ff   <= s1_move && (s1_col_ff == hi_addr);
      end
      if (s1_move) begin
         left_word_ff <= mid_word;
         recent_ff    <= {recent_ff[HIST_W-CH_W-1:0], s1_ch_ff};
         rsp_hits_ff  <= hits;
         rsp_total_ff <= sum_sat;
         rsp_done_ff  <= s1_flags_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hits_here     = rsp_hits_ff;
   assign rsp_running_total = rsp_total_ff;
   assign rsp_grid_done     = rsp_done_ff;

endmodule

`default_nettype wire

[rtl/gwsc_checker.sv]
`default_nettype none

module gwsc_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [gwsc_pkg::HITS_W-1:0]      rsp_hits_here,
   input wire logic [gwsc_pkg::TOTAL_W-1:0]     rsp_running_total,
   input wire logic                             rsp_grid_done
);
   import gwsc_pkg::*;

   // at most eight windows per cell
   hits_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hits_here <= HITS_W'(2 * (WORD_LEN)))
   ) else $error("hits above eight");

   // the total includes this cell's hits
   total_covers_hits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_running_total >= TOTAL_W'(rsp_hits_here))
   ) else $error("total below hits of this cell");

   // reset empties the result register
   reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid
   ) else $error("result valid after reset");

   // a stalled result holds
   stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_hits_here)
         && $stable(rsp_running_total) && $stable(rsp_grid_done))
   ) else $error("stalled result changed");

endmodule

bind grid_word_search_counter gwsc_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_hits_here     (rsp_hits_here),
   .rsp_running_total (rsp_running_total),
   .rsp_grid_done     (rsp_grid_done)
);

`default_nettype wire

[tb/tb_grid_word_search_counter.sv]
`default_nettype none

module tb_grid_word_search_counter;
   timeunit 1ns;
   timeprecision 1ps;

   import gwsc_pkg::*;

   localparam int CLK_PERIOD   = 12;
   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int MAXW         = MAX_WIDTH_DEF;
   localparam int TOTAL_CAP    = int'(TOTAL_MAX);
   localparam int RANDOM_ITEMS = 1000;
   localparam int FINAL_WIDTH  = 16;
   localparam int FINAL_ROWS   = 8;

   // one expected result word
   typedef struct packed {
      logic [HITS_W-1:0]  hits;
      logic [TOTAL_W-1:0] total;
      logic               done;
   } tally_type;

   // how a grid is filled
   typedef enum int {
      FILL_SCATTER,         // random letters of the search word
      FILL_STRIPES_NOISY,   // letter stripes along one direction, some cells replaced
      FILL_STRIPES,         // clean letter stripes
      FILL_NOISE            // half arbitrary bytes
   } fill_mode_type;

   // ---------------------------------------------------------------------
   // scoreboard: tracks the grid position, the last three rows and the
   // running total, and queues the tally each character should produce
   // ---------------------------------------------------------------------
   class word_match_board_type;
      logic [ROW_WIDTH_W-1:0] width_raw;
      logic [WORD_W-1:0]      word;
      logic [CH_W-1:0]        lines [3][MAXW];
      logic [CH_W-1:0]        recent [3];
      int                     row_slot;
      int                     column_pos;
      int                     rows_seen;
      int                     total;
      int                     errors;
      tally_type              tallies_due [$];

      function new();
         width_raw = ROW_WIDTH_RST;
         word      = SEARCH_WORD_RST;
         for (int s = 0; s < 3; s++) begin
            for (int c = 0; c < MAXW; c++) begin
               lines[s][c] = '0;
            end
            recent[s] = '0;
         end
         row_slot   = 0;
         column_pos = 0;
         rows_seen  = 0;
         total      = 0;
         errors     = 0;
      endfunction

      function void configure(logic [ROW_WIDTH_W-1:0] width_val, logic [WORD_W-1:0] word_val);
         width_raw = width_val;
         word      = word_val;
      endfunction

      function int row_len();
         if (width_raw == 0) return 1;
         if (width_raw > MAXW) return MAXW;
         return int'(width_raw);
      endfunction

      function logic [CH_W-1:0] letter(int i);
         return word[CH_W*(3-i) +: CH_W];
      endfunction

      // window in raster order, a3 is the newest cell
      function int window_score(logic [CH_W-1:0] a0, a1, a2, a3);
         logic [WORD_W-1:0] win;
         logic [WORD_W-1:0] flip;
         win  = {a0, a1, a2, a3};
         flip = {word[7:0], word[15:8], word[23:16], word[31:24]};
         return int'(win == word) + int'(win == flip);
      endfunction

      function void take_char(logic [CH_W-1:0] ch, logic last);
         int        w;
         int        c;
         int        up1;
         int        up2;
         int        up3;
         int        hits;
         bit        row_end;
         tally_type t;
         w       = row_len();
         c       = column_pos;
         up1     = row_slot;
         up2     = (row_slot + 2) % 3;
         up3     = (row_slot + 1) % 3;
         row_end = (c + 1 >= w);
         hits    = 0;
         if (c >= 3) hits += window_score(recent[2], recent[1], recent[0], ch);
         if (rows_seen >= 3) begin
            hits += window_score(lines[up3][c], lines[up2][c], lines[up1][c], ch);
            if (c >= 3)
               hits += window_score(lines[up3][c-3], lines[up2][c-2], lines[up1][c-1], ch);
            if (c + 3 < w)
               hits += window_score(lines[up3][c+3], lines[up2][c+2], lines[up1][c+1], ch);
         end
         total += hits;
         if (total > TOTAL_CAP) total = TOTAL_CAP;
         t.hits  = HITS_W'(hits);
         t.total = TOTAL_W'(total);
         t.done  = last;
         tallies_due.push_back(t);

         // the row lands three columns late so up-left reads still see the old row
         if (c >= 3) lines[up3][c-3] = recent[2];
         if (row_end) begin
            if (c >= 2) lines[up3][c-2] = recent[1];
            if (c >= 1) lines[up3][c-1] = recent[0];
            lines[up3][c] = ch;
         end
         recent[2] = recent[1];
         recent[1] = recent[0];
         recent[0] = ch;

         if (last) begin
            column_pos = 0;
            rows_seen  = 0;
            row_slot   = 0;
            total      = 0;
         end else if (row_end) begin
            column_pos = 0;
            if (rows_seen < 3) rows_seen++;
            row_slot = up3;
         end else begin
            column_pos = c + 1;
         end
      endfunction

      function void report(string field, logic [TOTAL_W-1:0] exp_v, logic [TOTAL_W-1:0] act_v);
         errors++;
         $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
      endfunction

      function void check_tally(logic [HITS_W-1:0] hits, logic [TOTAL_W-1:0] total_out,
                                logic done);
         tally_type t;
         if (tallies_due.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected result, expected none actual %0d/%0d/%0d",
                     $time, hits, total_out, done);
            return;
         end
         t = tallies_due.pop_front();
         if (hits !== t.hits)
            report("hits_here", TOTAL_W'(t.hits), TOTAL_W'(hits));
         if (total_out !== t.total)
            report("running_total", t.total, total_out);
         if (done !== t.done)
            report("grid_done", TOTAL_W'(t.done), TOTAL_W'(done));
      endfunction

      function int pending();
         return tallies_due.size();
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // block hookup, every input known from time zero
   // ---------------------------------------------------------------------
   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   logic [CH_W-1:0]        req_ch           = '0;
   logic                   req_last_of_grid = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   logic [HITS_W-1:0]      rsp_hits_here;
   logic [TOTAL_W-1:0]     rsp_running_total;
   logic                   rsp_grid_done;
   logic                   csr_write_en     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = CSR_ROW_WIDTH;
   logic [WORD_W-1:0]      csr_wdata        = '0;

   word_match_board_type board;
   bit                   idling = 1'b1;   // random gaps and stalls allowed

   grid_word_search_counter uut (.*);

   // free-running clock
   initial begin
      forever #(CLK_PERIOD/2) clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #(CLK_PERIOD * LIMIT_CYCLES);
      $display("timeout after %0d cycles", LIMIT_CYCLES);
      $display("*** FAILED ***");
      $finish;
   end

   // result side: check every accepted word, then pick ready for the next edge
   initial begin : result_side
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1)
            board.check_tally(rsp_hits_here, rsp_running_total, rsp_grid_done);
         if (idling && stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idling && $urandom_range(0, 7) == 0) begin
            // start a stall burst
            stall_left = $urandom_range(0, 10);
            rsp_ready <= 1'b0;
         end else begin
            stall_left = 0;
            rsp_ready <= 1'b1;
         end
      end
   end

   // one character word; valid holds until the handshake
   task automatic send_char(input logic [CH_W-1:0] ch, input logic last);
      if (idling && $urandom_range(0, 5) == 0) begin
         // sender gap with valid low
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_ch           <= ch;
      req_last_of_grid <= last;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      board.take_char(ch, last);
   endtask

   // stop sending and let every outstanding result come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // both registers, back to back, only while the block is idle
   task automatic program_regs(input logic [WORD_W-1:0] width_data,
                               input logic [WORD_W-1:0] word_data);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_ROW_WIDTH;
      csr_wdata    <= width_data;
      @(posedge clock);
      csr_index    <= CSR_SEARCH_WORD;
      csr_wdata    <= word_data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      board.configure(width_data[ROW_WIDTH_W-1:0], word_data);
   endtask

   // cell content; stripes repeat the search letters along (dr, dc)
   function automatic logic [CH_W-1:0] pick_char(fill_mode_type mode, int r, int c,
                                                 int dr, int dc);
      int idx;
      idx = ((r * dr + c * dc) % 4 + 4) % 4;
      case (mode)
         FILL_STRIPES_NOISY: if ($urandom_range(0, 9) != 0) return board.letter(idx);
         FILL_STRIPES:       return board.letter(idx);
         FILL_NOISE:         if ($urandom_range(0, 1) == 0) return CH_W'($urandom);
         default: ;
      endcase
      return board.letter($urandom_range(0, 3));
   endfunction

   // count characters at the current width; close marks the final one
   task automatic send_grid(input int count, input fill_mode_type mode, input int dr,
                            input int dc, input bit close);
      int w;
      w = board.row_len();
      for (int i = 0; i < count; i++)
         send_char(pick_char(mode, i / w, i % w, dr, dc), close && (i == count - 1));
   endtask

   // mostly narrow rows, now and then the odd and oversized widths
   function automatic logic [WORD_W-1:0] pick_width();
      logic [ROW_WIDTH_W-1:0] w9;
      logic [WORD_W-1:0]      hi;
      if ($urandom_range(0, 15) == 0) begin
         case ($urandom_range(0, 5))
            0:       w9 = 9'd0;
            1:       w9 = 9'd140;
            2:       w9 = 9'd255;
            3:       w9 = 9'd256;
            4:       w9 = 9'd300;
            default: w9 = 9'd511;
         endcase
      end else begin
         w9 = ROW_WIDTH_W'($urandom_range(1, 12));
      end
      // upper data bits are ignored by the width register
      hi = $urandom;
      if ($urandom_range(0, 3) == 0) return {hi[WORD_W-1:ROW_WIDTH_W], w9};
      return {{(WORD_W-ROW_WIDTH_W){1'b0}}, w9};
   endfunction

   // default, random, palindromes, one repeated letter and the all-0/all-1 words
   function automatic logic [WORD_W-1:0] pick_word();
      logic [CH_W-1:0] a;
      logic [CH_W-1:0] b;
      a = CH_W'($urandom_range(8'h41, 8'h5A));
      b = CH_W'($urandom_range(8'h41, 8'h5A));
      case ($urandom_range(0, 7))
         0, 1: return SEARCH_WORD_RST;
         2:    return {a, b, CH_W'($urandom_range(8'h41, 8'h5A)),
                       CH_W'($urandom_range(8'h41, 8'h5A))};
         3:    return {a, b, b, a};
         4:    return {a, a, a, a};
         5:    return '0;
         6:    return '1;
         default: return $urandom;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      logic [CH_W-1:0] corner_grid [16];
      logic [CH_W-1:0] column_grid [7];
      int              items;
      int              count;
      int              w;
      bit              first;

      board = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 4x4 grid: XMAS on the row, down-right diagonal and reversed on the
      // down-left diagonal, filler cells at both byte extremes
      corner_grid = '{LETTER_X, 8'h00,     8'h00,     LETTER_S,
                      8'hFF,    LETTER_M,  LETTER_A,  8'hFF,
                      8'h00,    LETTER_M,  LETTER_A,  8'h00,
                      LETTER_X, LETTER_M,  LETTER_A,  LETTER_S};
      program_regs(32'd4, SEARCH_WORD_RST);
      foreach (corner_grid[i]) send_char(corner_grid[i], i == 15);

      // zero width acts as a single column: forward then reversed vertically
      column_grid = '{LETTER_X, LETTER_M, LETTER_A, LETTER_S, LETTER_A, LETTER_M, LETTER_X};
      wait_for_results();
      program_regs(32'd0, SEARCH_WORD_RST);
      foreach (column_grid[i]) send_char(column_grid[i], i == 6);

      // random grids, registers reprogrammed between some of them
      items = 0;
      first = 1'b1;
      while (items < RANDOM_ITEMS) begin
         if (first || $urandom_range(0, 2) == 0) begin
            wait_for_results();
            program_regs(pick_width(), pick_word());
            first = 1'b0;
         end
         idling = ($urandom_range(0, 4) != 0);
         w      = board.row_len();
         count  = w * $urandom_range(1, 7);
         // some grids stop partway through a row
         if ($urandom_range(0, 3) == 0) count = $urandom_range(1, count);
         if (count > 300) count = $urandom_range(1, 300);
         send_grid(count, fill_mode_type'($urandom_range(0, 3)),
                   int'($urandom_range(0, 2)) - 1, int'($urandom_range(0, 2)) - 1, 1'b1);
         items += count;
      end

      // shrink the width mid-grid: the first character after the change sits
      // past the new last column and closes its row
      wait_for_results();
      idling = 1'b1;
      program_regs(32'd8, SEARCH_WORD_RST);
      send_grid(20, FILL_STRIPES_NOISY, 0, 1, 1'b0);
      wait_for_results();
      program_regs(32'd3, SEARCH_WORD_RST);
      send_grid(16, FILL_STRIPES_NOISY, 1, 0, 1'b1);

      // last stretch, no idling: one letter everywhere, so most cells score
      // several windows at once
      wait_for_results();
      idling = 1'b0;
      program_regs(WORD_W'(FINAL_WIDTH), 32'h4141_4141);
      send_grid(FINAL_ROWS * FINAL_WIDTH, FILL_STRIPES, 0, 0, 1'b1);
      // short grid right after shows the total cleared
      send_grid(8, FILL_STRIPES, 0, 0, 1'b1);

      wait_for_results();
      repeat (8) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
